### rtl/srfifo_pkg.sv
// shared constants and types of the sized ring fifo with peek
// no dependencies; imported by the ram user, the top level and the checker
package srfifo_pkg;

  // store geometry
  localparam int unsigned DEPTH        = 4096;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned ADDR_WIDTH   = $clog2(DEPTH);
  localparam int unsigned COUNT_WIDTH  = ADDR_WIDTH + 1;
  localparam int unsigned STEP_WIDTH   = $clog2(ADDR_WIDTH);

  // beat layouts, lowest field first
  localparam int unsigned OP_WIDTH      = 2;
  localparam int unsigned STATUS_WIDTH  = 2;
  localparam int unsigned IN_SAMPLE_LSB = OP_WIDTH;
  localparam int unsigned IN_POS_LSB    = IN_SAMPLE_LSB + SAMPLE_WIDTH;
  localparam int unsigned IN_BITS       = IN_POS_LSB + ADDR_WIDTH;
  localparam int unsigned IN_DATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_SAMPLE_LSB = STATUS_WIDTH;
  localparam int unsigned OUT_COUNT_LSB  = OUT_SAMPLE_LSB + SAMPLE_WIDTH;
  localparam int unsigned OUT_BITS       = OUT_COUNT_LSB + COUNT_WIDTH;
  localparam int unsigned OUT_DATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

### rtl/srfifo_ram.sv
// generic single-clock ram, one write and one read port, registered read
// no dependencies
module srfifo_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sized_ring_fifo_with_peek_unit.sv
// Results: push, flush and refused push or pop give their result beat straight from the
// result register set at acceptance; pop first reads the ram, peek first runs 12 steps
// of the bit-serial position modulo size, then a ram read. One item is in flight at a
// time; the next is taken once the result register is free or being emptied.
// Reset: pointers and count clear, size is DEPTH; the store is not swept, a high-water
// mark of written entries makes a peek beyond it read zero. Uses srfifo_pkg, srfifo_ram.
module sized_ring_fifo_with_peek_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config: queue_size
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srfifo_pkg::COUNT_WIDTH-1:0]  cfg_data_i,
  // op [1:0], sample_in [17:2], position [29:18], zero fill above
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [srfifo_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata_i,
  // status [1:0], sample_out [17:2], count [30:18], zero fill above
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [srfifo_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata_o
);
  import srfifo_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_MOD,
    S_PEEK_RD
  } state_e;

  state_e                  state_q;
  logic [ADDR_WIDTH-1:0]   head_q, tail_q;
  logic [COUNT_WIDTH-1:0]  fill_q, size_q, hw_q;
  logic [ADDR_WIDTH-1:0]   rem_q, pos_q;
  logic [STEP_WIDTH-1:0]   step_q;
  logic                    hit_q;
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [SAMPLE_WIDTH-1:0] out_sample_q;
  logic [COUNT_WIDTH-1:0]  out_count_q;

  // input beat fields
  op_e                     in_op;
  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic [ADDR_WIDTH-1:0]   in_pos;

  logic                    in_beat, cfg_beat, out_free;
  logic                    is_full, is_empty;
  logic [COUNT_WIDTH-1:0]  tail_inc, head_inc, cfg_size;
  logic [COUNT_WIDTH-1:0]  rem_shift, rem_sub;
  logic [ADDR_WIDTH-1:0]   rem_new;
  logic                    last_step;

  logic                    ram_we, ram_re;
  logic [ADDR_WIDTH-1:0]   ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  assign in_op     = op_e'(s_axis_tdata_i[OP_WIDTH-1:0]);
  assign in_sample = s_axis_tdata_i[IN_SAMPLE_LSB +: SAMPLE_WIDTH];
  assign in_pos    = s_axis_tdata_i[IN_POS_LSB +: ADDR_WIDTH];

  // handshakes, a pending config write holds off the input beat
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_beat        = cfg_valid_i && cfg_ready_o;

  // occupancy and pointer increments with wrap at the configured size
  assign is_full  = (fill_q >= size_q);
  assign is_empty = (fill_q == '0);
  assign tail_inc = {1'b0, tail_q} + COUNT_WIDTH'(1);
  assign head_inc = {1'b0, head_q} + COUNT_WIDTH'(1);

  // size written is clamped to 1..DEPTH
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_size = COUNT_WIDTH'(1);
    end else if (cfg_data_i > COUNT_WIDTH'(DEPTH)) begin
      cfg_size = COUNT_WIDTH'(DEPTH);
    end else begin
      cfg_size = cfg_data_i;
    end
  end

  // one restoring remainder step per cycle: position modulo size
  assign rem_shift = {rem_q, pos_q[ADDR_WIDTH-1]};
  assign rem_sub   = rem_shift - size_q;
  assign rem_new   = (rem_shift >= size_q) ? rem_sub[ADDR_WIDTH-1:0]
                                           : rem_shift[ADDR_WIDTH-1:0];
  assign last_step = (step_q == STEP_WIDTH'(ADDR_WIDTH - 1));

  // ram controls
  assign ram_we    = in_beat && (in_op == OP_PUSH) && !is_full;
  assign ram_re    = (in_beat && (in_op == OP_POP) && !is_empty) ||
                     ((state_q == S_MOD) && last_step);
  assign ram_raddr = (state_q == S_MOD) ? rem_new : head_q;

  srfifo_ram #(
    .Width (SAMPLE_WIDTH),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_sample),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer, pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      hw_q         <= '0;
      size_q       <= COUNT_WIDTH'(DEPTH);
      rem_q        <= '0;
      pos_q        <= '0;
      step_q       <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_sample_q <= '0;
      out_count_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_beat) begin
        size_q <= cfg_size;
        head_q <= '0;
        tail_q <= '0;
        fill_q <= '0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            unique case (in_op)
              OP_PUSH: begin
                out_valid_q  <= 1'b1;
                out_sample_q <= '0;
                if (is_full) begin
                  out_status_q <= ST_FULL;
                  out_count_q  <= fill_q;
                end else begin
                  out_status_q <= ST_OK;
                  out_count_q  <= fill_q + COUNT_WIDTH'(1);
                  fill_q       <= fill_q + COUNT_WIDTH'(1);
                  tail_q       <= (tail_inc == size_q) ? '0 : tail_inc[ADDR_WIDTH-1:0];
                  if (tail_inc > hw_q) begin
                    hw_q <= tail_inc;
                  end
                end
              end
              OP_POP: begin
                if (is_empty) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= ST_EMPTY;
                  out_sample_q <= '0;
                  out_count_q  <= fill_q;
                end else begin
                  fill_q  <= fill_q - COUNT_WIDTH'(1);
                  head_q  <= (head_inc == size_q) ? '0 : head_inc[ADDR_WIDTH-1:0];
                  state_q <= S_POP_RD;
                end
              end
              OP_PEEK: begin
                rem_q   <= '0;
                pos_q   <= in_pos;
                step_q  <= '0;
                state_q <= S_MOD;
              end
              OP_FLUSH: begin
                head_q       <= '0;
                tail_q       <= '0;
                fill_q       <= '0;
                out_valid_q  <= 1'b1;
                out_status_q <= ST_OK;
                out_sample_q <= '0;
                out_count_q  <= '0;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_POP_RD: begin
          out_valid_q  <= 1'b1;
          out_status_q <= ST_OK;
          out_sample_q <= ram_rdata;
          out_count_q  <= fill_q;
          state_q      <= S_IDLE;
        end
        S_MOD: begin
          rem_q  <= rem_new;
          pos_q  <= {pos_q[ADDR_WIDTH-2:0], 1'b0};
          step_q <= step_q + STEP_WIDTH'(1);
          if (last_step) begin
            // entries at or above the high-water mark were never written
            hit_q   <= ({1'b0, rem_new} < hw_q);
            state_q <= S_PEEK_RD;
          end
        end
        S_PEEK_RD: begin
          out_valid_q  <= 1'b1;
          out_status_q <= ST_OK;
          out_sample_q <= hit_q ? ram_rdata : '0;
          out_count_q  <= fill_q;
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_WIDTH - OUT_BITS)'(0), out_count_q, out_sample_q,
                            out_status_q};

endmodule

### rtl/srfifo_checker.sv
// port-level checks of the sized ring fifo with peek, bound to the top level
// depends on srfifo_pkg and sized_ring_fifo_with_peek_unit
module srfifo_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  input logic [srfifo_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata_o
);
  import srfifo_pkg::*;

  logic [STATUS_WIDTH-1:0] st;
  logic [SAMPLE_WIDTH-1:0] smp;
  logic [COUNT_WIDTH-1:0]  cnt;

  assign st  = m_axis_tdata_o[STATUS_WIDTH-1:0];
  assign smp = m_axis_tdata_o[OUT_SAMPLE_LSB +: SAMPLE_WIDTH];
  assign cnt = m_axis_tdata_o[OUT_COUNT_LSB +: COUNT_WIDTH];

  // count never exceeds the store depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt <= COUNT_WIDTH'(DEPTH))
    else $error("count beyond depth");

  // a refused operation carries no sample
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (st == ST_FULL || st == ST_EMPTY) |-> smp == '0)
    else $error("refused beat carries a sample");

  // empty refusal only with nothing stored, full refusal only with something stored
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ST_EMPTY |-> cnt == '0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ST_FULL |-> cnt != '0)
    else $error("full status with zero count");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

endmodule

bind sized_ring_fifo_with_peek_unit srfifo_checker u_srfifo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### tb/tb_sized_ring_fifo_with_peek_unit.sv
`timescale 1ns / 100ps
// self-checking bench for the sized ring fifo with peek: directed table then random phases,
// results compared beat by beat with an in-bench model or typed rows; uses srfifo_pkg, rtl
module tb_sized_ring_fifo_with_peek_unit;
  import srfifo_pkg::*;

  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE  = 60;
  localparam int unsigned NUM_PHASES       = 10;
  localparam int unsigned NUM_DIR_ROWS     = 27;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_e;

  typedef struct packed {
    status_e                  status;
    logic [SAMPLE_WIDTH-1:0]  sample;
    logic [COUNT_WIDTH-1:0]   count;
  } fifo_result_t;

  typedef struct packed {
    row_kind_e                kind;
    op_e                      op;
    logic [SAMPLE_WIDTH-1:0]  smp;
    logic [ADDR_WIDTH-1:0]    pos;
    logic                     typed;
    fifo_result_t             res;
    logic [COUNT_WIDTH-1:0]   size;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [COUNT_WIDTH-1:0]     cfg_data_i;
  logic                       s_axis_tvalid_i;
  logic                       s_axis_tready_o;
  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata_i;   // op, sample_in, position, zero fill
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i;
  logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata_o;   // status, sample_out, count, zero fill

  // model of the fifo state
  logic [SAMPLE_WIDTH-1:0]    store_model [DEPTH];
  int unsigned                head_model;
  int unsigned                tail_model;
  int unsigned                fill_model;
  int unsigned                size_model;

  fifo_result_t               pending_results [$];
  fifo_result_t               want;
  int unsigned                fail_count = 0;
  bit                         src_idle_on = 1'b1;
  bit                         sink_idle_on = 1'b1;
  bit                         hold_sink = 1'b0;

  // directed rows: typed results only where obvious, the rest come from the model
  stim_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_ITEM, OP_POP,   16'h0000, 12'h000, 1'b1, '{ST_EMPTY, 16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PEEK,  16'h0000, 12'hfff, 1'b1, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'hffff, 12'h000, 1'b1, '{ST_OK,    16'h0000, 13'd1}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'h0000, 12'hfff, 1'b1, '{ST_OK,    16'h0000, 13'd2}, 13'd0},
    '{ROW_ITEM, OP_PEEK,  16'h0000, 12'h000, 1'b1, '{ST_OK,    16'hffff, 13'd2}, 13'd0},
    '{ROW_ITEM, OP_POP,   16'h0000, 12'h000, 1'b1, '{ST_OK,    16'hffff, 13'd1}, 13'd0},
    '{ROW_ITEM, OP_POP,   16'h0000, 12'h000, 1'b1, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_POP,   16'hffff, 12'hfff, 1'b1, '{ST_EMPTY, 16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'h1234, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_FLUSH, 16'hffff, 12'hfff, 1'b1, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    // flush leaves the store alone
    '{ROW_ITEM, OP_PEEK,  16'h0000, 12'h002, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    // size zero behaves as one entry
    '{ROW_SIZE, OP_PUSH,  16'h0000, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'ha5a5, 12'h000, 1'b1, '{ST_OK,    16'h0000, 13'd1}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'h5a5a, 12'h000, 1'b1, '{ST_FULL,  16'h0000, 13'd1}, 13'd0},
    '{ROW_ITEM, OP_PEEK,  16'h0000, 12'hfff, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_POP,   16'h0000, 12'h000, 1'b1, '{ST_OK,    16'ha5a5, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_POP,   16'h0000, 12'h000, 1'b1, '{ST_EMPTY, 16'h0000, 13'd0}, 13'd0},
    // oversize saturates to the full store
    '{ROW_SIZE, OP_PUSH,  16'h0000, 12'h000, 1'b0, '{ST_OK, 16'h0000, 13'd0}, 13'h1fff},
    '{ROW_ITEM, OP_PEEK,  16'h0000, 12'hfff, 1'b0, '{ST_OK, 16'h0000, 13'd0}, 13'd0},
    // two entries, fill and wrap
    '{ROW_SIZE, OP_PUSH,  16'h0000, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd2},
    '{ROW_ITEM, OP_PUSH,  16'h8001, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'h7ffe, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'h1111, 12'h000, 1'b1, '{ST_FULL,  16'h0000, 13'd2}, 13'd0},
    '{ROW_ITEM, OP_POP,   16'h0000, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PUSH,  16'h2222, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_ITEM, OP_PEEK,  16'h0000, 12'h003, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd0},
    '{ROW_SIZE, OP_PUSH,  16'h0000, 12'h000, 1'b0, '{ST_OK,    16'h0000, 13'd0}, 13'd4096}
  };

  sized_ring_fifo_with_peek_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one fifo operation on the model, returns the result beat it should give
  function automatic fifo_result_t fifo_step(input op_e op, input logic [SAMPLE_WIDTH-1:0] smp,
                                             input logic [ADDR_WIDTH-1:0] pos);
    fifo_result_t r;
    r.status = ST_OK;
    r.sample = '0;
    case (op)
      OP_PUSH: begin
        if (fill_model >= size_model) begin
          r.status = ST_FULL;
        end else begin
          store_model[tail_model] = smp;
          tail_model = (tail_model + 1) % size_model;
          fill_model++;
        end
      end
      OP_POP: begin
        if (fill_model == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.sample = store_model[head_model];
          head_model = (head_model + 1) % size_model;
          fill_model--;
        end
      end
      OP_PEEK: begin
        r.sample = store_model[int'(pos) % size_model];
      end
      default: begin
        head_model = 0;
        tail_model = 0;
        fill_model = 0;
      end
    endcase
    r.count = fill_model[COUNT_WIDTH-1:0];
    return r;
  endfunction

  // block until every expected result beat has been seen
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // write queue_size while the block is idle
  task automatic write_queue_size(input logic [COUNT_WIDTH-1:0] v);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_model = (v == 0) ? 1 : (v > DEPTH) ? DEPTH : int'(v);
    head_model = 0;
    tail_model = 0;
    fill_model = 0;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // offer one beat, record its expected result once accepted
  task automatic send_item(input op_e op, input logic [SAMPLE_WIDTH-1:0] smp,
                           input logic [ADDR_WIDTH-1:0] pos, input logic typed,
                           input fifo_result_t typed_res);
    fifo_result_t r;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tdata_i = '0;
    s_axis_tdata_i[OP_WIDTH-1:0] = op;
    s_axis_tdata_i[IN_SAMPLE_LSB +: SAMPLE_WIDTH] = smp;
    s_axis_tdata_i[IN_POS_LSB +: ADDR_WIDTH] = pos;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = fifo_step(op, smp, pos);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // weighted op choice, leaning towards filling or draining
  function automatic op_e pick_op(input bit filling);
    int unsigned r = $urandom_range(0, 99);
    if (r < (filling ? 60 : 20)) return OP_PUSH;
    if (r < 80) return OP_POP;
    if (r < 96) return OP_PEEK;
    return OP_FLUSH;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %0h", m_axis_tdata_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[STATUS_WIDTH-1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 m_axis_tdata_o[STATUS_WIDTH-1:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[OUT_SAMPLE_LSB +: SAMPLE_WIDTH] !== want.sample) begin
          $error("sample_out: expected %0h, got %0h", want.sample,
                 m_axis_tdata_o[OUT_SAMPLE_LSB +: SAMPLE_WIDTH]);
          fail_count++;
        end
        if (m_axis_tdata_o[OUT_COUNT_LSB +: COUNT_WIDTH] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count,
                 m_axis_tdata_o[OUT_COUNT_LSB +: COUNT_WIDTH]);
          fail_count++;
        end
      end
    end
  end

  // result side back-pressure: short random bursts, or one long hold on request
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready_i = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        hold_sink = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    logic [COUNT_WIDTH-1:0]  sz;
    logic [ADDR_WIDTH-1:0]   pos;
    bit                      filling;
    int unsigned             pos_max;
    fifo_result_t            none;

    none = '{ST_OK, '0, '0};
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    foreach (store_model[i]) store_model[i] = '0;
    head_model = 0;
    tail_model = 0;
    fill_model = 0;
    size_model = DEPTH;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIZE) begin
        write_queue_size(dir_rows[i].size);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].pos, dir_rows[i].typed,
                  dir_rows[i].res);
      end
    end

    // random phases, each under its own size
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: sz = 13'd1;
        1: sz = 13'd3;
        2: sz = 13'd7;
        3: sz = 13'd16;
        4: sz = 13'd4096;
        5: sz = 13'd0;
        6: sz = 13'h1fff;
        7: sz = 13'd5;
        8: sz = 13'($urandom_range(2, 64));
        default: sz = 13'($urandom_range(0, 8191));
      endcase
      write_queue_size(sz);
      filling = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 12 == 0) begin
          filling = (n % 24 == 0);
          src_idle_on  = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
          sink_idle_on = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        // long result stall while beats keep coming, so the input backs up
        if (ph == 1 && n == 10) hold_sink = 1'b1;
        // sender goes quiet until everything has come back
        if (ph == 3 && n == 30) wait_drained();
        pos_max = (size_model * 2 > DEPTH) ? DEPTH - 1 : size_model * 2 - 1;
        if ($urandom_range(0, 1) == 0) pos = ADDR_WIDTH'($urandom_range(0, DEPTH - 1));
        else pos = ADDR_WIDTH'($urandom_range(0, pos_max));
        send_item(pick_op(filling), SAMPLE_WIDTH'($urandom), pos, 1'b0, none);
      end
    end

    // let every result come back, then a few more cycles for strays
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("sized_ring_fifo_with_peek_unit test passed");
    end else begin
      $display("sized_ring_fifo_with_peek_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("sized_ring_fifo_with_peek_unit test failed");
    $finish;
  end

endmodule
